>>> rtl/core/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg - shared types and arithmetic for the affine matrix concatenator
// Word types for both channels, function codes, and the single precision
// multiply and add used by the datapath (round to nearest even).
// ----------------------------------------------------------------------------
package amc_pkg;

    // Function codes of an input word.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_APPLY = 1'b1;

    localparam int ROWS  = 3;
    localparam int LANES = 4;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] POS_ZERO     = 32'h0000_0000;

    typedef struct packed {
        logic        func;
        logic [1:0]  row_index;
        logic [31:0] elem_x;
        logic [31:0] elem_y;
        logic [31:0] elem_z;
        logic [31:0] elem_w;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  out_row;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_w;
    } t_out_word;

    typedef logic [31:0] t_lane_vec [LANES];

    // Leading zero count of a 48-bit word.
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Leading zero count of a 28-bit word.
    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd28;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(27 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Single precision multiply, round to nearest even.
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0]        ma, mb;
        logic [7:0]         ea, eb;
        logic [47:0]        p, pn, ps;
        logic [5:0]         lz;
        logic signed [10:0] e;
        logic [10:0]        sh;
        logic               sticky, g, rnd;
        logic [30:0]        res;
        s      = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma     = {(a[30:23] != 8'd0), a[22:0]};
        mb     = {(b[30:23] != 8'd0), b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p      = 48'(ma) * 48'(mb);
        lz     = lzc48(p);
        pn     = p << lz;
        e      = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
                 - $signed({5'b00000, lz});
        // Results below the normal range are shifted into subnormal form.
        if (e < 11'sd1) begin
            sh = 11'(11'sd1 - e);
            if (sh > 11'd48) begin
                sh = 11'd48;
            end
            ps     = pn >> sh;
            sticky = ((ps << sh) != pn);
            res    = {8'd0, ps[46:24]};
            g      = ps[23];
            sticky = sticky | (ps[22:0] != 23'd0);
        end else begin
            ps     = pn;
            res    = {e[7:0], pn[46:24]};
            g      = pn[23];
            sticky = (pn[22:0] != 23'd0);
        end
        rnd = g & (sticky | res[0]);
        res = res + 31'(rnd);
        if (a_nan) begin
            return a | 32'h0040_0000;
        end else if (b_nan) begin
            return b | 32'h0040_0000;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            return QNAN_DEFAULT;
        end else if (a_inf || b_inf) begin
            return {s, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            return {s, 31'd0};
        end else if (e >= 11'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, res};
    endfunction

    // Single precision add, round to nearest even.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        x, y;
        logic               a_nan, b_nan, a_inf, b_inf;
        logic [26:0]        mx, my, mys;
        logic [7:0]         ex, ey, d;
        logic               st;
        logic [27:0]        sum, sn;
        logic [4:0]         lz, lzc;
        logic [8:0]         e;
        logic [7:0]         efield;
        logic               g, sticky, rnd;
        logic [30:0]        res;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        // Larger magnitude goes to x.
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        mx  = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        my  = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d   = ex - ey;
        if (d > 8'd27) begin
            mys = 27'd0;
            st  = (my != 27'd0);
        end else begin
            mys = my >> d;
            st  = ((mys << d) != my);
        end
        mys = mys | 27'(st);
        if (x[31] == y[31]) begin
            sum = {1'b0, mx} + {1'b0, mys};
        end else begin
            sum = {1'b0, mx} - {1'b0, mys};
        end
        lz  = lzc28(sum);
        lzc = (9'(lz) > 9'(ex)) ? ex[4:0] : lz;
        sn  = sum << lzc;
        e   = 9'(ex) + 9'd1 - 9'(lzc);
        efield = sn[27] ? e[7:0] : 8'd0;
        res    = {efield, sn[26:4]};
        g      = sn[3];
        sticky = (sn[2:0] != 3'd0);
        rnd    = g & (sticky | res[0]);
        res    = res + 31'(rnd);
        if (a_nan) begin
            return a | 32'h0040_0000;
        end else if (b_nan) begin
            return b | 32'h0040_0000;
        end else if (a_inf && b_inf && (a[31] != b[31])) begin
            return QNAN_DEFAULT;
        end else if (a_inf) begin
            return a;
        end else if (b_inf) begin
            return b;
        end else if (sum == 28'd0) begin
            return {(x[31] & y[31]), 31'd0};
        end else if (sn[27] && (e >= 9'd255)) begin
            return {x[31], 8'hFF, 23'd0};
        end
        return {x[31], res};
    endfunction

endpackage

>>> rtl/core/affine_matrix_concat.sv
// ----------------------------------------------------------------------------
// affine_matrix_concat - composes two 3x4 single precision affine transforms
// Right matrix rows are loaded into a register file; each left matrix row
// yields one product row through a four stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid, i_in_data, o_in_stall) takes one word per
//   cycle while o_in_stall is low. A load word (func = load) writes one
//   row of the right matrix and produces nothing; a load to row three is
//   dropped. An apply word (func = apply) produces one product row on the
//   output channel (o_out_valid, o_out_data, i_out_stall).
//   An apply word passes through the input register, then the multiply
//   stage and two add stages, the last of which is the output register.
//   Throughput: one word per cycle while the receiver does not stall; the
//   twelve multipliers and two adder levels per lane each occupy one
//   pipeline stage.
//   Reset clears all pipeline valid bits; the right matrix is not cleared
//   and must be loaded before the first apply word.
//   While the receiver stalls, the pipeline keeps filling its empty stages
//   and o_in_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module affine_matrix_concat (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  amc_pkg::t_in_word   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output amc_pkg::t_out_word  o_out_data,
    input  logic                i_out_stall
);

    logic [31:0]        r_mat [amc_pkg::ROWS * amc_pkg::LANES];
    logic [3:0]         mat_base;
    logic [3:0]         r_v;
    logic [3:0]         free;
    logic               accept;

    // Stage 0: left row and snapshot of the right matrix.
    logic [1:0]         r_s0_row;
    logic [31:0]        r_s0_a [amc_pkg::LANES];
    logic [31:0]        r_s0_m [amc_pkg::ROWS * amc_pkg::LANES];
    // Stage 1: products.
    logic [1:0]         r_s1_row;
    logic [31:0]        r_s1_p [amc_pkg::LANES * 4];
    logic [31:0]        n_s1_p [amc_pkg::LANES * 4];
    // Stage 2: pair sums.
    logic [1:0]         r_s2_row;
    logic [31:0]        r_s2_s [amc_pkg::LANES * 2];
    logic [31:0]        n_s2_s [amc_pkg::LANES * 2];
    // Stage 3: result word.
    amc_pkg::t_out_word r_s3;
    amc_pkg::t_lane_vec n_s3_r;

    // Stage advance: a stage may load when its successor is free or moving.
    assign free[3] = !r_v[3] || !i_out_stall;
    assign free[2] = !r_v[2] || free[3];
    assign free[1] = !r_v[1] || free[2];
    assign free[0] = !r_v[0] || free[1];
    assign accept     = i_in_valid && free[0];
    assign o_in_stall = !free[0];

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'd0;
        end else begin
            if (free[0]) begin
                r_v[0] <= accept && (i_in_data.func == amc_pkg::FUNC_APPLY);
            end
            if (free[1]) begin
                r_v[1] <= r_v[0];
            end
            if (free[2]) begin
                r_v[2] <= r_v[1];
            end
            if (free[3]) begin
                r_v[3] <= r_v[2];
            end
        end
    end

    // First entry of the addressed row in the register file.
    assign mat_base = {i_in_data.row_index, 2'b00};

    // Right matrix register file, written by load words.
    always_ff @(posedge i_clk) begin
        if (accept && (i_in_data.func == amc_pkg::FUNC_LOAD)
            && (i_in_data.row_index != 2'd3)) begin
            r_mat[mat_base]         <= i_in_data.elem_x;
            r_mat[mat_base + 4'd1]  <= i_in_data.elem_y;
            r_mat[mat_base + 4'd2]  <= i_in_data.elem_z;
            r_mat[mat_base + 4'd3]  <= i_in_data.elem_w;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (free[0]) begin
            r_s0_row  <= i_in_data.row_index;
            r_s0_a[0] <= i_in_data.elem_x;
            r_s0_a[1] <= i_in_data.elem_y;
            r_s0_a[2] <= i_in_data.elem_z;
            r_s0_a[3] <= i_in_data.elem_w;
            r_s0_m    <= r_mat;
        end
    end

    // Multiply stage; the fourth term is the translation in lane 3, else +0.
    always_comb begin
        for (int j = 0; j < amc_pkg::LANES; j++) begin
            n_s1_p[4 * j + 0] = amc_pkg::fp_mul(r_s0_a[0], r_s0_m[0 * 4 + j]);
            n_s1_p[4 * j + 1] = amc_pkg::fp_mul(r_s0_a[1], r_s0_m[1 * 4 + j]);
            n_s1_p[4 * j + 2] = amc_pkg::fp_mul(r_s0_a[2], r_s0_m[2 * 4 + j]);
            n_s1_p[4 * j + 3] = (j == amc_pkg::LANES - 1) ? r_s0_a[3]
                                                          : amc_pkg::POS_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[1]) begin
            r_s1_row <= r_s0_row;
            r_s1_p   <= n_s1_p;
        end
    end

    // First add level: (p0 + p1) and (p2 + p3) per lane.
    always_comb begin
        for (int j = 0; j < amc_pkg::LANES; j++) begin
            n_s2_s[2 * j + 0] = amc_pkg::fp_add(r_s1_p[4 * j + 0], r_s1_p[4 * j + 1]);
            n_s2_s[2 * j + 1] = amc_pkg::fp_add(r_s1_p[4 * j + 2], r_s1_p[4 * j + 3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[2]) begin
            r_s2_row <= r_s1_row;
            r_s2_s   <= n_s2_s;
        end
    end

    // Second add level forms the result row.
    always_comb begin
        for (int j = 0; j < amc_pkg::LANES; j++) begin
            n_s3_r[j] = amc_pkg::fp_add(r_s2_s[2 * j + 0], r_s2_s[2 * j + 1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[3]) begin
            r_s3.out_row <= r_s2_row;
            r_s3.out_x   <= n_s3_r[0];
            r_s3.out_y   <= n_s3_r[1];
            r_s3.out_z   <= n_s3_r[2];
            r_s3.out_w   <= n_s3_r[3];
        end
    end

    assign o_out_valid = r_v[3];
    assign o_out_data  = r_s3;

    // A stalled result word stays in the output register.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && i_out_stall) |=> (r_v[3] && $stable(r_s3)))
        else $error("stalled result word lost or changed");

    // Input stalls only when every stage is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v == 4'hF) && i_out_stall)
        else $error("input stalled with a free stage");

    // An accepted apply word enters the input register.
    a_apply_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_data.func == amc_pkg::FUNC_APPLY)) |=> r_v[0])
        else $error("apply word dropped");

    // A load word never sets the valid bit of the input register.
    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_data.func == amc_pkg::FUNC_LOAD)) |=> !r_v[0])
        else $error("load word produced a result");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - affine matrix concatenator check
// Loads rows of the right matrix and applies left matrix rows, predicting each
// product row with a bit-exact single precision model written here in integer
// arithmetic, and compares every output word field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TIMEOUT_CYCLES = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    amc_pkg::t_in_word  i_in_data = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    amc_pkg::t_out_word o_out_data;
    logic               i_out_stall = 1'b0;

    affine_matrix_concat dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Shadow copy of the right matrix and the product rows still owed.
    logic [31:0]        right_rows [amc_pkg::ROWS][amc_pkg::LANES];
    amc_pkg::t_out_word owed_rows[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    bit                 steady_sender = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Rounds sign * mag * 2^lsb to single precision, nearest even.
    function automatic logic [31:0] round_single(input logic s, input logic [279:0] mag,
                                                 input int lsb);
        int           msb;
        int           sh;
        logic [279:0] m;
        logic         half;
        logic         sticky;
        longint       enc;
        msb = 0;
        for (int i = 0; i < 280; i++) begin
            if (mag[i]) msb = i;
        end
        sh = msb - 23;
        if (sh < -149 - lsb) sh = -149 - lsb;
        if (sh <= 0) begin
            m      = mag << (-sh);
            half   = 1'b0;
            sticky = 1'b0;
        end else begin
            m      = mag >> sh;
            half   = mag[sh-1];
            sticky = (mag & ((280'd1 << (sh - 1)) - 280'd1)) != 280'd0;
        end
        if (half && (sticky || m[0])) m = m + 280'd1;
        // Normal and subnormal encodings share this form; a carry bumps the exponent.
        enc = longint'(lsb + sh + 149) * 64'h80_0000 + longint'(m[24:0]);
        if (enc >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
        return {s, enc[30:0]};
    endfunction

    function automatic bit is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    // Significand as an integer and the weight of its lowest bit.
    function automatic logic [23:0] signif(input logic [31:0] v);
        return {(v[30:23] != 8'd0), v[22:0]};
    endfunction

    function automatic int lsb_exp(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? -149 : int'(v[30:23]) - 150;
    endfunction

    function automatic logic [31:0] mul_single(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a)) return a | 32'h0040_0000;
        if (is_nan(b)) return b | 32'h0040_0000;
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
            return 32'hFFC0_0000;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
        return round_single(s, 280'(48'(signif(a)) * 48'(signif(b))),
                            lsb_exp(a) + lsb_exp(b));
    endfunction

    function automatic logic [31:0] add_single(input logic [31:0] a, input logic [31:0] b);
        logic [279:0] ma;
        logic [279:0] mb;
        logic [279:0] mag;
        logic         s;
        if (is_nan(a)) return a | 32'h0040_0000;
        if (is_nan(b)) return b | 32'h0040_0000;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return 32'hFFC0_0000;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        // Both operands are exact multiples of the smallest subnormal.
        ma = 280'(signif(a)) << (lsb_exp(a) + 149);
        mb = 280'(signif(b)) << (lsb_exp(b) + 149);
        if (a[31] == b[31]) begin
            mag = ma + mb;
            s   = a[31];
        end else if (ma >= mb) begin
            mag = ma - mb;
            s   = a[31];
        end else begin
            mag = mb - ma;
            s   = b[31];
        end
        if (mag == 280'd0) return {a[31] & b[31], 31'd0};
        return round_single(s, mag, -149);
    endfunction

    // Tracks loads and works out the product row of each apply word.
    task automatic predict_word(input amc_pkg::t_in_word w);
        logic [31:0]        a [amc_pkg::LANES];
        logic [31:0]        lane_out [amc_pkg::LANES];
        logic [31:0]        p0, p1, p2, p3;
        amc_pkg::t_out_word row_out;
        a = '{w.elem_x, w.elem_y, w.elem_z, w.elem_w};
        if (w.func == amc_pkg::FUNC_LOAD) begin
            if (w.row_index < 2'(amc_pkg::ROWS)) begin
                for (int j = 0; j < amc_pkg::LANES; j++) right_rows[w.row_index][j] = a[j];
            end
        end else begin
            for (int j = 0; j < amc_pkg::LANES; j++) begin
                p0 = mul_single(a[0], right_rows[0][j]);
                p1 = mul_single(a[1], right_rows[1][j]);
                p2 = mul_single(a[2], right_rows[2][j]);
                p3 = (j == amc_pkg::LANES - 1) ? a[3] : amc_pkg::POS_ZERO;
                lane_out[j] = add_single(add_single(p0, p1), add_single(p2, p3));
            end
            row_out.out_row = w.row_index;
            row_out.out_x   = lane_out[0];
            row_out.out_y   = lane_out[1];
            row_out.out_z   = lane_out[2];
            row_out.out_w   = lane_out[3];
            owed_rows.push_back(row_out);
        end
    endtask

    // Sends one word in bursts with random gaps in between.
    task automatic send_word(input logic f, input logic [1:0] row, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [31:0] w);
        amc_pkg::t_in_word word;
        int                gap;
        word = '{func: f, row_index: row, elem_x: x, elem_y: y, elem_z: z, elem_w: w};
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = steady_sender ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= word;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(word);
    endtask

    // Holds the sender off until every owed row has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (owed_rows.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Random element: mostly moderate values, plus subnormals and specials.
    function automatic logic [31:0] rand_elem();
        logic [31:0] specials [10];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h7F7F_FFFF,
                     32'h5555_5555, 32'hAAAA_AAAA};
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {1'($urandom()), 8'd0, 23'($urandom())};
            2: return specials[$urandom_range(0, 9)];
            default: return {1'($urandom()), 8'($urandom_range(110, 145)), 23'($urandom())};
        endcase
    endfunction

    // Identity, extremes, signed zeros, specials and the row three cases.
    task automatic test_directed();
        send_word(amc_pkg::FUNC_LOAD, 2'd0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000);
        send_word(amc_pkg::FUNC_LOAD, 2'd1, 32'h0000_0000, 32'h3F80_0000, 32'h0000_0000,
                  32'h0000_0000);
        send_word(amc_pkg::FUNC_LOAD, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000,
                  32'h0000_0000);
        // A load to row three must leave the matrix alone.
        send_word(amc_pkg::FUNC_LOAD, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_word(amc_pkg::FUNC_APPLY, 2'd0, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000,
                  32'h40A0_0000);
        send_word(amc_pkg::FUNC_APPLY, 2'd3, 32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000,
                  32'hC000_0000);
        // Negative zero products turn positive in the first three lanes.
        send_word(amc_pkg::FUNC_APPLY, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000);
        send_word(amc_pkg::FUNC_APPLY, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000);
        send_word(amc_pkg::FUNC_APPLY, 2'd2, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0001,
                  32'h7F7F_FFFF);
        send_word(amc_pkg::FUNC_APPLY, 2'd1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFF80_0000,
                  32'h7F80_0001);
        send_word(amc_pkg::FUNC_LOAD, 2'd0, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000,
                  32'h8000_0000);
        send_word(amc_pkg::FUNC_LOAD, 2'd1, 32'h7F7F_FFFF, 32'h807F_FFFF, 32'hFF80_0000,
                  32'h0080_0000);
        send_word(amc_pkg::FUNC_LOAD, 2'd2, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                  32'h5555_5555);
        // Overflow, subnormal, infinity times zero and opposite infinities.
        send_word(amc_pkg::FUNC_APPLY, 2'd0, 32'h4000_0000, 32'h3F80_0000, 32'h3F80_0000,
                  32'h0000_0000);
        send_word(amc_pkg::FUNC_APPLY, 2'd1, 32'h3F00_0000, 32'h3F00_0000, 32'h0000_0000,
                  32'hAAAA_AAAA);
        send_word(amc_pkg::FUNC_APPLY, 2'd2, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
                  32'h7F80_0000);
        send_word(amc_pkg::FUNC_APPLY, 2'd3, 32'hBF80_0000, 32'h0000_0000, 32'h3F80_0000,
                  32'hFF80_0000);
        send_word(amc_pkg::FUNC_APPLY, 2'd0, 32'h0000_0000, 32'h3F80_0000, 32'h8000_0000,
                  32'h0000_0001);
    endtask

    // Random row updates and applies, with some dropped row three loads.
    task automatic test_random(input int n_items);
        int done;
        int pick;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send_word(amc_pkg::FUNC_LOAD, 2'd3, $urandom(), $urandom(), $urandom(),
                          $urandom());
            end else begin
                send_word(pick < 3 ? amc_pkg::FUNC_LOAD : amc_pkg::FUNC_APPLY,
                          pick < 3 ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3)),
                          rand_elem(), rand_elem(), rand_elem(), rand_elem());
                done++;
            end
        end
    endtask

    // Back to back words with no sender gaps.
    task automatic test_full_rate(input int n_items);
        steady_sender = 1'b1;
        test_random(n_items);
        steady_sender = 1'b0;
    endtask

    // Receiver stall pattern; the mode steps through four settings as cycle_count grows.
    always @(posedge i_clk) begin
        case ((cycle_count / 64) % 4)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 9) < 3);
            2: i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    // Compares each accepted output word with the oldest owed row.
    always @(posedge i_clk) begin
        amc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_rows.size() == 0) begin
                $error("unexpected output word %h", o_out_data);
                error_count++;
            end else begin
                want = owed_rows.pop_front();
                if (o_out_data.out_row !== want.out_row) begin
                    $error("out_row: expected %h, got %h", want.out_row, o_out_data.out_row);
                    error_count++;
                end
                if (o_out_data.out_x !== want.out_x) begin
                    $error("out_x: expected %h, got %h", want.out_x, o_out_data.out_x);
                    error_count++;
                end
                if (o_out_data.out_y !== want.out_y) begin
                    $error("out_y: expected %h, got %h", want.out_y, o_out_data.out_y);
                    error_count++;
                end
                if (o_out_data.out_z !== want.out_z) begin
                    $error("out_z: expected %h, got %h", want.out_z, o_out_data.out_z);
                    error_count++;
                end
                if (o_out_data.out_w !== want.out_w) begin
                    $error("out_w: expected %h, got %h", want.out_w, o_out_data.out_w);
                    error_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(400);
        test_full_rate(250);
        wait_drained();
        if (owed_rows.size() != 0) begin
            $error("%0d product rows never arrived", owed_rows.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
